/* rtl/core/ddmt_pkg.sv */
`default_nettype none

package ddmt_pkg;

    // Field widths of the item and result channels.
    localparam int OPC_W      = 2;
    localparam int IN_W       = 24;
    localparam int DRV_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Four wheels; the mean error is the sum shifted right by this amount.
    localparam int NUM_WHEELS  = 4;
    localparam int WHEEL_SHIFT = $clog2(NUM_WHEELS);

    // Internal datapath widths.
    localparam int DEG_W  = 25;              // distance in encoder degrees
    localparam int WT_W   = 26;              // wheel target
    localparam int AVG_W  = 27;              // mean wheel error
    localparam int SUM_W  = AVG_W + WHEEL_SHIFT;
    localparam int HD_W   = 25;              // heading deviation
    localparam int ERR_W  = 26;              // turn error
    localparam int MARG_W = 11;              // move margin in degrees
    localparam int L_W    = 45;              // mixed side command
    localparam int TP1_W  = ERR_W + 16;      // turn error times gain
    localparam int NUM_W  = 52;              // divider dividend
    localparam int Q_W    = 7;               // divider quotient
    localparam int CNT_W  = 3;               // divider step counter

    // Wheel constant: 289/256 encoder degrees per 0.1 cm.
    localparam int WHEEL_Q8 = 289;
    localparam int WHEEL_K_W = 10;
    localparam int Q_SHIFT  = 8;
    localparam logic signed [WHEEL_K_W-1:0] WHEEL_K = WHEEL_K_W'(WHEEL_Q8);

    // Turn scale: Q8.8 gain, percent and hundredths of a degree.
    localparam int TURN_DIV_INT = 2560000;
    localparam logic [NUM_W-1:0] TURN_DIV = NUM_W'(TURN_DIV_INT);
    localparam logic [NUM_W-1:0] TURN_SAT = NUM_W'(TURN_DIV_INT * (2 ** Q_W));

    localparam logic [Q_W-1:0] DRIVE_MAX = Q_W'(100);

    // Configuration reset values.
    localparam logic [6:0]  SPEED_RST      = 7'd50;
    localparam logic [9:0]  DIST_MARG_RST  = 10'd10;
    localparam logic [15:0] DIST_GAIN_RST  = 16'd256;
    localparam logic [15:0] HEAD_GAIN_RST  = 16'd256;
    localparam logic [14:0] TURN_MARG_RST  = 15'd100;
    localparam logic [15:0] TURN_GAIN_RST  = 16'd256;

    typedef enum logic [OPC_W-1:0] {
        OPC_SAMPLE = 2'd0,
        OPC_MOVE   = 2'd1,
        OPC_TURN   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_TURN = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED      = 3'd0,
        CFG_DIST_MARG  = 3'd1,
        CFG_DIST_GAIN  = 3'd2,
        CFG_HEAD_GAIN  = 3'd3,
        CFG_TURN_MARG  = 3'd4,
        CFG_TURN_GAIN  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [6:0]  speed_percent;
        logic [9:0]  distance_margin;
        logic [15:0] distance_gain;
        logic [15:0] heading_gain;
        logic [14:0] turn_margin;
        logic [15:0] turn_gain;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PREP,
        OP_LATCH,
        OP_ERR,
        OP_RES_DONE,
        OP_RES_ZERO,
        OP_MOVE_MUL,
        OP_MIX,
        OP_MAG,
        OP_MAX,
        OP_DIV_LEFT,
        OP_DIV_RIGHT,
        OP_TURN_MUL1,
        OP_TURN_MUL2,
        OP_DIV_TURN,
        OP_DIV_STEP,
        OP_STORE_LEFT,
        OP_STORE_RIGHT,
        OP_STORE_TURN
    } dp_op_t;

    typedef struct packed {
        logic   load_in;
        logic   post;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  in_margin;
        logic  lr_zero;
        logic  div_last;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_LATCH,
        ST_ERR,
        ST_EVAL,
        ST_MIX,
        ST_MAG,
        ST_MAX,
        ST_LDIVL,
        ST_DIVL,
        ST_STL,
        ST_LDIVR,
        ST_DIVR,
        ST_STR,
        ST_TMUL2,
        ST_LDIVT,
        ST_DIVT,
        ST_STT,
        ST_POST
    } ctrl_state_t;

endpackage

`default_nettype wire

/* rtl/core/ddmt_cfg.sv */
`default_nettype none

module ddmt_cfg (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wen,
    input  wire  [ddmt_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire  [ddmt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ddmt_pkg::cfg_t                     cfg
);
    import ddmt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_SPEED:     cfg_next.speed_percent   = cfg_data[6:0];
                CFG_DIST_MARG: cfg_next.distance_margin = cfg_data[9:0];
                CFG_DIST_GAIN: cfg_next.distance_gain   = cfg_data;
                CFG_HEAD_GAIN: cfg_next.heading_gain    = cfg_data;
                CFG_TURN_MARG: cfg_next.turn_margin     = cfg_data[14:0];
                CFG_TURN_GAIN: cfg_next.turn_gain       = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_percent   <= SPEED_RST;
            cfg_reg.distance_margin <= DIST_MARG_RST;
            cfg_reg.distance_gain   <= DIST_GAIN_RST;
            cfg_reg.heading_gain    <= HEAD_GAIN_RST;
            cfg_reg.turn_margin     <= TURN_MARG_RST;
            cfg_reg.turn_gain       <= TURN_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/ddmt_ctrl.sv */
`default_nettype none

module ddmt_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    input  wire ddmt_pkg::dp_stat_t stat,
    output ddmt_pkg::dp_cmd_t      cmd
);
    import ddmt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Sequencer: one step of the datapath per state.
    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.post    = 1'b0;
        cmd.op      = OP_NONE;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                cmd.op     = OP_LATCH;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.mode == MODE_IDLE || stat.in_margin)
                begin
                    cmd.op     = OP_RES_DONE;
                    state_next = ST_POST;
                end
                else if (stat.mode == MODE_MOVE)
                begin
                    cmd.op     = OP_MOVE_MUL;
                    state_next = ST_MIX;
                end
                else
                begin
                    cmd.op     = OP_TURN_MUL1;
                    state_next = ST_TMUL2;
                end
            end
            ST_MIX:
            begin
                cmd.op     = OP_MIX;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = ST_MAX;
            end
            ST_MAX:
            begin
                if (stat.lr_zero)
                begin
                    cmd.op     = OP_RES_ZERO;
                    state_next = ST_POST;
                end
                else
                begin
                    cmd.op     = OP_MAX;
                    state_next = ST_LDIVL;
                end
            end
            ST_LDIVL:
            begin
                cmd.op     = OP_DIV_LEFT;
                state_next = ST_DIVL;
            end
            ST_DIVL:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_STL;
                end
            end
            ST_STL:
            begin
                cmd.op     = OP_STORE_LEFT;
                state_next = ST_LDIVR;
            end
            ST_LDIVR:
            begin
                cmd.op     = OP_DIV_RIGHT;
                state_next = ST_DIVR;
            end
            ST_DIVR:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_STR;
                end
            end
            ST_STR:
            begin
                cmd.op     = OP_STORE_RIGHT;
                state_next = ST_POST;
            end
            ST_TMUL2:
            begin
                cmd.op     = OP_TURN_MUL2;
                state_next = ST_LDIVT;
            end
            ST_LDIVT:
            begin
                cmd.op     = OP_DIV_TURN;
                state_next = ST_DIVT;
            end
            ST_DIVT:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_STT;
                end
            end
            ST_STT:
            begin
                cmd.op     = OP_STORE_TURN;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register stays full until the item is taken.
    always_comb
    begin
        if (cmd.post)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is never posted over one that is still waiting.
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!out_valid_reg || out_ready))
        else $error("result posted while output register full");

    // The output register only fills from the post state.
    a_valid_from_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_POST))
        else $error("output valid raised outside post state");

endmodule

`default_nettype wire

/* rtl/core/ddmt_dpath.sv */
`default_nettype none

module ddmt_dpath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire ddmt_pkg::cfg_t                  cfg,
    input  wire ddmt_pkg::dp_cmd_t               cmd,
    output ddmt_pkg::dp_stat_t                   stat,
    input  wire        [ddmt_pkg::OPC_W-1:0]     opcode,
    input  wire signed [ddmt_pkg::IN_W-1:0]      target,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_left_front,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_left_back,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_right_front,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_right_back,
    input  wire signed [ddmt_pkg::IN_W-1:0]      heading,
    output logic signed [ddmt_pkg::DRV_W-1:0]    left_drive,
    output logic signed [ddmt_pkg::DRV_W-1:0]    right_drive,
    output logic                                 done_res
);
    import ddmt_pkg::*;

    // Captured item.
    logic        [OPC_W-1:0] op_reg,   op_next;
    logic signed [IN_W-1:0]  tgt_reg,  tgt_next;
    logic signed [IN_W-1:0]  enc_reg  [NUM_WHEELS];
    logic signed [IN_W-1:0]  enc_next [NUM_WHEELS];
    logic signed [IN_W-1:0]  head_reg, head_next;

    // Controller state kept across items.
    mode_t                   mode_reg, mode_next;
    logic signed [WT_W-1:0]  wt_reg  [NUM_WHEELS];
    logic signed [WT_W-1:0]  wt_next [NUM_WHEELS];
    logic signed [IN_W-1:0]  sh_reg,   sh_next;
    logic signed [IN_W-1:0]  tt_reg,   tt_next;

    // Working registers.
    logic signed [DEG_W-1:0] deg_reg,  deg_next;
    logic        [MARG_W-1:0] mdeg_reg, mdeg_next;
    logic signed [AVG_W-1:0] avg_reg,  avg_next;
    logic signed [HD_W-1:0]  hd_reg,   hd_next;
    logic signed [ERR_W-1:0] e_reg,    e_next;
    logic signed [L_W-1:0]   d_reg,    d_next;
    logic signed [L_W-1:0]   h_reg,    h_next;
    logic signed [L_W-1:0]   l_reg,    l_next;
    logic signed [L_W-1:0]   r_reg,    r_next;
    logic        [L_W-1:0]   magl_reg, magl_next;
    logic        [L_W-1:0]   magr_reg, magr_next;
    logic        [L_W-1:0]   m_reg,    m_next;
    logic                    lneg_reg, lneg_next;
    logic                    rneg_reg, rneg_next;
    logic                    tneg_reg, tneg_next;
    logic        [TP1_W-1:0] tp1_reg,  tp1_next;

    // Shared restoring divider.
    logic        [NUM_W-1:0] rem_reg,  rem_next;
    logic        [NUM_W-1:0] dsh_reg,  dsh_next;
    logic        [Q_W-1:0]   q_reg,    q_next;
    logic        [CNT_W-1:0] cnt_reg,  cnt_next;
    logic                    sat_reg,  sat_next;

    // Result staging and output register.
    logic signed [DRV_W-1:0] res_left_reg,  res_left_next;
    logic signed [DRV_W-1:0] res_right_reg, res_right_next;
    logic                    res_done_reg,  res_done_next;
    logic signed [DRV_W-1:0] left_drive_reg,  left_drive_next;
    logic signed [DRV_W-1:0] right_drive_reg, right_drive_next;
    logic                    done_res_reg,    done_res_next;

    // Combinational helpers.
    logic signed [IN_W+WHEEL_K_W-1:0] deg_prod;
    logic        [MARG_W+Q_SHIFT+1:0] marg_prod;
    logic signed [SUM_W-1:0]          wsum;
    logic        [AVG_W-1:0]          mag_avg;
    logic        [ERR_W-1:0]          mag_e;
    logic signed [16:0]               dg_s;
    logic signed [16:0]               hg_s;
    logic                             div_ge;
    logic        [Q_W-1:0]            q_clamp;

    function automatic logic signed [DRV_W-1:0] apply_sign(
        input logic [Q_W-1:0] v,
        input logic           neg
    );
        logic signed [DRV_W-1:0] s;
        s = $signed(DRV_W'(v));
        return neg ? -s : s;
    endfunction

    // Distance and margin in encoder degrees: multiply by 289, floor by 256.
    assign deg_prod  = (IN_W+WHEEL_K_W)'(tgt_reg) * (IN_W+WHEEL_K_W)'(WHEEL_K);
    assign marg_prod = (MARG_W+Q_SHIFT+2)'(cfg.distance_margin)
                     * (MARG_W+Q_SHIFT+2)'(WHEEL_Q8);

    // Sum of the wheel errors; the mean is taken by an arithmetic shift.
    always_comb
    begin
        wsum = '0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            wsum = wsum + SUM_W'(wt_reg[i]) - SUM_W'(enc_reg[i]);
        end
    end

    assign mag_avg = avg_reg[AVG_W-1] ? AVG_W'(-avg_reg) : AVG_W'(avg_reg);
    assign mag_e   = e_reg[ERR_W-1]   ? ERR_W'(-e_reg)   : ERR_W'(e_reg);
    assign dg_s    = $signed({1'b0, cfg.distance_gain});
    assign hg_s    = $signed({1'b0, cfg.heading_gain});
    assign div_ge  = (rem_reg >= dsh_reg);

    // Quotient saturated to the drive range.
    assign q_clamp = (sat_reg || (q_reg > DRIVE_MAX)) ? DRIVE_MAX : q_reg;

    // Status back to the controller.
    always_comb
    begin
        stat.mode = mode_reg;
        if (mode_reg == MODE_MOVE)
        begin
            stat.in_margin = (mag_avg <= AVG_W'(mdeg_reg));
        end
        else
        begin
            stat.in_margin = (mag_e <= ERR_W'(cfg.turn_margin));
        end
        stat.lr_zero  = (l_reg == '0) && (r_reg == '0);
        stat.div_last = (cnt_reg == '0);
    end

    // One datapath operation per cycle, chosen by the controller.
    always_comb
    begin
        op_next   = op_reg;
        tgt_next  = tgt_reg;
        head_next = head_reg;
        mode_next = mode_reg;
        sh_next   = sh_reg;
        tt_next   = tt_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            enc_next[i] = enc_reg[i];
            wt_next[i]  = wt_reg[i];
        end
        deg_next  = deg_reg;
        mdeg_next = mdeg_reg;
        avg_next  = avg_reg;
        hd_next   = hd_reg;
        e_next    = e_reg;
        d_next    = d_reg;
        h_next    = h_reg;
        l_next    = l_reg;
        r_next    = r_reg;
        magl_next = magl_reg;
        magr_next = magr_reg;
        m_next    = m_reg;
        lneg_next = lneg_reg;
        rneg_next = rneg_reg;
        tneg_next = tneg_reg;
        tp1_next  = tp1_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_done_next  = res_done_reg;

        if (cmd.load_in)
        begin
            op_next     = opcode;
            tgt_next    = target;
            enc_next[0] = enc_left_front;
            enc_next[1] = enc_left_back;
            enc_next[2] = enc_right_front;
            enc_next[3] = enc_right_back;
            head_next   = heading;
        end

        case (cmd.op)
            OP_PREP:
            begin
                deg_next  = deg_prod[DEG_W+Q_SHIFT-1:Q_SHIFT];
                mdeg_next = marg_prod[MARG_W+Q_SHIFT-1:Q_SHIFT];
            end
            OP_LATCH:
            begin
                if (op_reg == OPC_MOVE)
                begin
                    for (int i = 0; i < NUM_WHEELS; i++)
                    begin
                        wt_next[i] = WT_W'(enc_reg[i]) + WT_W'(deg_reg);
                    end
                    sh_next   = head_reg;
                    mode_next = MODE_MOVE;
                end
                else if (op_reg == OPC_TURN)
                begin
                    sh_next   = head_reg;
                    tt_next   = tgt_reg;
                    mode_next = MODE_TURN;
                end
            end
            OP_ERR:
            begin
                avg_next = wsum[SUM_W-1:WHEEL_SHIFT];
                hd_next  = HD_W'(sh_reg) - HD_W'(head_reg);
                e_next   = ERR_W'(tt_reg) - ERR_W'(head_reg) + ERR_W'(sh_reg);
            end
            OP_RES_DONE:
            begin
                mode_next      = MODE_IDLE;
                res_left_next  = '0;
                res_right_next = '0;
                res_done_next  = 1'b1;
            end
            OP_RES_ZERO:
            begin
                res_left_next  = '0;
                res_right_next = '0;
                res_done_next  = 1'b0;
            end
            OP_MOVE_MUL:
            begin
                d_next = avg_reg * dg_s;
                h_next = hd_reg * hg_s;
            end
            OP_MIX:
            begin
                l_next = d_reg + h_reg;
                r_next = d_reg - h_reg;
            end
            OP_MAG:
            begin
                magl_next = l_reg[L_W-1] ? L_W'(-l_reg) : L_W'(l_reg);
                magr_next = r_reg[L_W-1] ? L_W'(-r_reg) : L_W'(r_reg);
                lneg_next = l_reg[L_W-1];
                rneg_next = r_reg[L_W-1];
            end
            OP_MAX:
            begin
                m_next = (magl_reg > magr_reg) ? magl_reg : magr_reg;
            end
            OP_DIV_LEFT:
            begin
                rem_next = NUM_W'(magl_reg) * NUM_W'(cfg.speed_percent);
                dsh_next = NUM_W'(m_reg) << (Q_W - 1);
                q_next   = '0;
                cnt_next = CNT_W'(Q_W - 1);
                sat_next = 1'b0;
            end
            OP_DIV_RIGHT:
            begin
                rem_next = NUM_W'(magr_reg) * NUM_W'(cfg.speed_percent);
                dsh_next = NUM_W'(m_reg) << (Q_W - 1);
                q_next   = '0;
                cnt_next = CNT_W'(Q_W - 1);
                sat_next = 1'b0;
            end
            OP_TURN_MUL1:
            begin
                tp1_next  = TP1_W'(mag_e) * TP1_W'(cfg.turn_gain);
                tneg_next = e_reg[ERR_W-1];
            end
            OP_TURN_MUL2:
            begin
                rem_next = NUM_W'(tp1_reg) * NUM_W'(cfg.speed_percent);
            end
            OP_DIV_TURN:
            begin
                // Beyond 128 times the divisor the drive is saturated anyway.
                sat_next = (rem_reg >= TURN_SAT);
                dsh_next = TURN_DIV << (Q_W - 1);
                q_next   = '0;
                cnt_next = CNT_W'(Q_W - 1);
            end
            OP_DIV_STEP:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[Q_W-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_STORE_LEFT:
            begin
                res_left_next = apply_sign(q_clamp, lneg_reg);
                res_done_next = 1'b0;
            end
            OP_STORE_RIGHT:
            begin
                res_right_next = apply_sign(q_clamp, rneg_reg);
            end
            OP_STORE_TURN:
            begin
                res_left_next  = apply_sign(q_clamp, tneg_reg);
                res_right_next = apply_sign(q_clamp, !tneg_reg);
                res_done_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Output register loads when the controller posts a result.
    always_comb
    begin
        if (cmd.post)
        begin
            left_drive_next  = res_left_reg;
            right_drive_next = res_right_reg;
            done_res_next    = res_done_reg;
        end
        else
        begin
            left_drive_next  = left_drive_reg;
            right_drive_next = right_drive_reg;
            done_res_next    = done_res_reg;
        end
    end

    // Mode and latched heading and turn target reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            sh_reg   <= '0;
            tt_reg   <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            sh_reg   <= sh_next;
            tt_reg   <= tt_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tgt_reg  <= tgt_next;
        head_reg <= head_next;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            enc_reg[i] <= enc_next[i];
            wt_reg[i]  <= wt_next[i];
        end
        deg_reg  <= deg_next;
        mdeg_reg <= mdeg_next;
        avg_reg  <= avg_next;
        hd_reg   <= hd_next;
        e_reg    <= e_next;
        d_reg    <= d_next;
        h_reg    <= h_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        magl_reg <= magl_next;
        magr_reg <= magr_next;
        m_reg    <= m_next;
        lneg_reg <= lneg_next;
        rneg_reg <= rneg_next;
        tneg_reg <= tneg_next;
        tp1_reg  <= tp1_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        res_left_reg    <= res_left_next;
        res_right_reg   <= res_right_next;
        res_done_reg    <= res_done_next;
        left_drive_reg  <= left_drive_next;
        right_drive_reg <= right_drive_next;
        done_res_reg    <= done_res_next;
    end

    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign done_res    = done_res_reg;

    // A quotient is stored only straight after the last divide step.
    a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_STORE_LEFT || cmd.op == OP_STORE_RIGHT
            || cmd.op == OP_STORE_TURN)
        |-> ($past(cmd.op == OP_DIV_STEP) && $past(cnt_reg == '0)))
        else $error("quotient stored before the divide finished");

    // A done result always carries zero drive.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post && res_done_reg) |-> (res_left_reg == '0 && res_right_reg == '0))
        else $error("done result with non-zero drive");

    // Move mode is entered only by latching a start-move item.
    a_move_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MOVE && $past(mode_reg != MODE_MOVE))
        |-> $past(cmd.op == OP_LATCH && op_reg == OPC_MOVE))
        else $error("move mode entered without a start-move item");

endmodule

`default_nettype wire

/* rtl/core/diff_drive_move_turn_p_control_core.sv */
// Channel   Signals                                        Handshake
// config    cfg_wen, cfg_idx, cfg_data                     write on cfg_wen, no wait
// item in   opcode, target, enc_*, heading                 in_valid / in_ready
// result    left_drive, right_drive, done_res              out_valid / out_ready
//
// Items are taken one at a time; a new item is accepted once the previous result has
// left the controller. Idle items, items inside the margin and moves with zero
// magnitude skip the shared 7-step restoring divider; a turn runs it once, a move twice.
// Reset is asynchronous and active low; configuration registers return to their
// defaults and the drive returns to idle mode.
// A new item is accepted while the previous result waits in the output register; a
// finished result waits in the controller until that register is free.
`default_nettype none

module diff_drive_move_turn_p_control_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wen,
    input  wire        [ddmt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire        [ddmt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire        [ddmt_pkg::OPC_W-1:0]     opcode,
    input  wire signed [ddmt_pkg::IN_W-1:0]      target,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_left_front,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_left_back,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_right_front,
    input  wire signed [ddmt_pkg::IN_W-1:0]      enc_right_back,
    input  wire signed [ddmt_pkg::IN_W-1:0]      heading,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [ddmt_pkg::DRV_W-1:0]    left_drive,
    output logic signed [ddmt_pkg::DRV_W-1:0]    right_drive,
    output logic                                 done_res
);
    import ddmt_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration register bank.
    ddmt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    // Sequencer and output handshake.
    ddmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic, drive state and result registers.
    ddmt_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .target          (target),
        .enc_left_front  (enc_left_front),
        .enc_left_back   (enc_left_back),
        .enc_right_front (enc_right_front),
        .enc_right_back  (enc_right_back),
        .heading         (heading),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .done_res        (done_res)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    import ddmt_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  RESET_CYCLES  = 7;
    localparam int  MAX_IDLE      = 10;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  PHASE_ITEMS   = 100;
    localparam int  RUN_LIMIT_NS  = 3_000_000;
    // The fourth opcode has no name in the package; the block treats it as a sample.
    localparam logic [OPC_W-1:0] OPC_SPARE = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]       op;
        logic signed [IN_W-1:0] tgt;
        logic signed [IN_W-1:0] enc_lf;
        logic signed [IN_W-1:0] enc_lb;
        logic signed [IN_W-1:0] enc_rf;
        logic signed [IN_W-1:0] enc_rb;
        logic signed [IN_W-1:0] hd;
    } sensor_item_t;

    typedef struct packed {
        logic signed [DRV_W-1:0] left;
        logic signed [DRV_W-1:0] right;
        logic                    finished;
    } drive_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OPC_W-1:0]        opcode = '0;
    logic signed [IN_W-1:0]  target = '0;
    logic signed [IN_W-1:0]  enc_left_front = '0;
    logic signed [IN_W-1:0]  enc_left_back = '0;
    logic signed [IN_W-1:0]  enc_right_front = '0;
    logic signed [IN_W-1:0]  enc_right_back = '0;
    logic signed [IN_W-1:0]  heading = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    done_res;

    // Predicted controller state and register copies.
    cfg_t    ctl_cfg;
    mode_t   drive_mode;
    longint  wheel_goal [NUM_WHEELS];
    longint  head_ref;
    longint  turn_goal;

    drive_result_t expected_drive [$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    bit            send_idle_on = 1'b1;
    bit            recv_idle_on = 1'b1;
    bit            hold_output = 1'b0;

    diff_drive_move_turn_p_control_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .target          (target),
        .enc_left_front  (enc_left_front),
        .enc_left_back   (enc_left_back),
        .enc_right_front (enc_right_front),
        .enc_right_back  (enc_right_back),
        .heading         (heading),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .done_res        (done_res)
    );

    // Free-running clock.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog for a hung run.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("diff_drive_move_turn_p_control_core verification failed");
        $finish;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [DRV_W-1:0] clamp_pct(input longint v);
        if (v > 100)
        begin
            return 8'sd100;
        end
        if (v < -100)
        begin
            return -8'sd100;
        end
        return v[DRV_W-1:0];
    endfunction

    // Uniform value in the range -r .. r.
    function automatic longint spread(input int r);
        return longint'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic sensor_item_t make_item(input logic [OPC_W-1:0] op, input longint tgt,
                                               input longint lf, input longint lb,
                                               input longint rf, input longint rb,
                                               input longint hd);
        sensor_item_t it;
        it.op     = op;
        it.tgt    = tgt[IN_W-1:0];
        it.enc_lf = lf[IN_W-1:0];
        it.enc_lb = lb[IN_W-1:0];
        it.enc_rf = rf[IN_W-1:0];
        it.enc_rb = rb[IN_W-1:0];
        it.hd     = hd[IN_W-1:0];
        return it;
    endfunction

    function automatic int draw_idle(input bit enabled);
        return enabled ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    // Works out the drive command for one accepted item and advances the state.
    task automatic predict_drive(input sensor_item_t it);
        longint        enc [NUM_WHEELS];
        longint        tgt, hd, deg, err_sum, mean_err, marg;
        longint        d, h, l, r, m, e, sp, kd, kh, kt, tmarg;
        drive_result_t res;
        int            i;
        tgt    = $signed(it.tgt);
        hd     = $signed(it.hd);
        enc[0] = $signed(it.enc_lf);
        enc[1] = $signed(it.enc_lb);
        enc[2] = $signed(it.enc_rf);
        enc[3] = $signed(it.enc_rb);
        sp     = ctl_cfg.speed_percent;
        kd     = ctl_cfg.distance_gain;
        kh     = ctl_cfg.heading_gain;
        kt     = ctl_cfg.turn_gain;
        tmarg  = ctl_cfg.turn_margin;
        res.left     = '0;
        res.right    = '0;
        res.finished = 1'b1;

        // Start items latch their targets, then are evaluated as samples.
        if (it.op == OPC_MOVE)
        begin
            deg = (tgt * WHEEL_Q8) >>> Q_SHIFT;
            for (i = 0; i < NUM_WHEELS; i++)
            begin
                wheel_goal[i] = enc[i] + deg;
            end
            head_ref   = hd;
            drive_mode = MODE_MOVE;
        end
        else if (it.op == OPC_TURN)
        begin
            head_ref   = hd;
            turn_goal  = tgt;
            drive_mode = MODE_TURN;
        end

        case (drive_mode)
            MODE_MOVE:
            begin
                err_sum = 0;
                for (i = 0; i < NUM_WHEELS; i++)
                begin
                    err_sum += wheel_goal[i] - enc[i];
                end
                mean_err = err_sum >>> WHEEL_SHIFT;
                marg = (longint'(ctl_cfg.distance_margin) * WHEEL_Q8) >>> Q_SHIFT;
                if (magnitude(mean_err) <= marg)
                begin
                    drive_mode = MODE_IDLE;
                end
                else
                begin
                    // Mean error mixed with the heading correction, scaled by the larger side.
                    d = mean_err * kd;
                    h = (head_ref - hd) * kh;
                    l = d + h;
                    r = d - h;
                    m = (magnitude(l) > magnitude(r)) ? magnitude(l) : magnitude(r);
                    res.finished = 1'b0;
                    if (m != 0)
                    begin
                        res.left  = clamp_pct(l * sp / m);
                        res.right = clamp_pct(r * sp / m);
                    end
                end
            end
            MODE_TURN:
            begin
                e = turn_goal - (hd - head_ref);
                if (magnitude(e) <= tmarg)
                begin
                    drive_mode = MODE_IDLE;
                end
                else
                begin
                    res.left     = clamp_pct(e * kt * sp / TURN_DIV_INT);
                    res.right    = -res.left;
                    res.finished = 1'b0;
                end
            end
            default:
            begin
                drive_mode = MODE_IDLE;
            end
        endcase
        expected_drive.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
                 $realtime, what, results_seen, got, want);
        mismatch_count++;
    endtask

    // Offers one item after a random gap and holds it until it is accepted.
    task automatic send_item(input sensor_item_t it);
        int gap;
        gap = draw_idle(send_idle_on);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        = 1'b1;
        opcode          = it.op;
        target          = it.tgt;
        enc_left_front  = it.enc_lf;
        enc_left_back   = it.enc_lb;
        enc_right_front = it.enc_rf;
        enc_right_back  = it.enc_rb;
        heading         = it.hd;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_drive(it);
        items_sent++;
    endtask

    // Lets every outstanding result drain, then lets the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_drive.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wen  = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        case (idx)
            CFG_SPEED:     ctl_cfg.speed_percent   = value[6:0];
            CFG_DIST_MARG: ctl_cfg.distance_margin = value[9:0];
            CFG_DIST_GAIN: ctl_cfg.distance_gain   = value;
            CFG_HEAD_GAIN: ctl_cfg.heading_gain    = value;
            CFG_TURN_MARG: ctl_cfg.turn_margin     = value[14:0];
            CFG_TURN_GAIN: ctl_cfg.turn_gain       = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic set_controls(input int speed, input int dmarg, input int dgain,
                                input int hgain, input int tmarg, input int tgain);
        wait_idle();
        write_reg(CFG_SPEED, CFG_DATA_W'(speed));
        write_reg(CFG_DIST_MARG, CFG_DATA_W'(dmarg));
        write_reg(CFG_DIST_GAIN, CFG_DATA_W'(dgain));
        write_reg(CFG_HEAD_GAIN, CFG_DATA_W'(hgain));
        write_reg(CFG_TURN_MARG, CFG_DATA_W'(tmarg));
        write_reg(CFG_TURN_GAIN, CFG_DATA_W'(tgain));
    endtask

    // A start-move item followed by samples that walk the wheels towards the target.
    task automatic drive_move_run(input int steps);
        longint base [NUM_WHEELS];
        longint move_len, deg, hd0, drift;
        int     i, j;
        move_len = spread($urandom_range(0, 1) ? 20000 : 500);
        deg      = (move_len * WHEEL_Q8) >>> Q_SHIFT;
        hd0      = spread(1 << 21);
        drift    = $urandom_range(0, 3) == 0 ? 5000 : 300;
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            base[i] = spread(1 << 21);
        end
        send_item(make_item(OPC_MOVE, move_len, base[0], base[1], base[2], base[3], hd0));
        for (j = 1; j <= steps; j++)
        begin
            send_item(make_item(OPC_SAMPLE, $urandom,
                                base[0] + deg * j / steps + spread(15),
                                base[1] + deg * j / steps + spread(15),
                                base[2] + deg * j / steps + spread(15),
                                base[3] + deg * j / steps + spread(15),
                                hd0 + spread(drift)));
        end
    endtask

    // A start-turn item followed by samples that rotate the heading towards the angle.
    task automatic drive_turn_run(input int steps);
        longint hd0, angle;
        int     j;
        hd0   = spread(1 << 21);
        angle = spread($urandom_range(0, 1) ? 36000 : 2000);
        send_item(make_item(OPC_TURN, angle, $urandom, $urandom, $urandom, $urandom, hd0));
        for (j = 1; j <= steps; j++)
        begin
            send_item(make_item(OPC_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                                hd0 + angle * j / steps + spread(80)));
        end
    endtask

    task automatic send_noise();
        send_item(make_item(OPC_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
    endtask

    // Result side: random stalls, one long hold on request, and the field check.
    initial
    begin : result_sink
        int            stall;
        drive_result_t want;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                stall = draw_idle(recv_idle_on);
                if (stall > 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            if (expected_drive.size() == 0)
            begin
                report_mismatch("unexpected result, left_drive", left_drive, 0);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (left_drive !== want.left)
                begin
                    report_mismatch("left_drive", left_drive, want.left);
                end
                if (right_drive !== want.right)
                begin
                    report_mismatch("right_drive", right_drive, want.right);
                end
                if (done_res !== want.finished)
                begin
                    report_mismatch("done_res", done_res, want.finished);
                end
            end
            results_seen++;
        end
    end

    // Idle samples, including the spare opcode and the field extremes.
    task automatic test_idle_samples();
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_SPARE, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        send_item(make_item(OPC_SAMPLE, -8388608, -8388608, -8388608, -8388608, -8388608,
                            -8388608));
    endtask

    task automatic test_move_directed();
        // Zero distance lands inside the margin at once.
        send_item(make_item(OPC_MOVE, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_MOVE, 8388607, 8388607, -8388608, 0, -1, 8388607));
        send_item(make_item(OPC_SAMPLE, 0, -8388608, -8388608, -8388608, -8388608, -8388608));
        send_item(make_item(OPC_MOVE, -8388608, 1000, 2000, -3000, 4000, 0));
        send_item(make_item(OPC_SPARE, 0, 900, 1900, -3100, 3900, 1000));
        // Encoders pushed past the field range wrap round, so the wheels end far off.
        send_item(make_item(OPC_SAMPLE, 0, 1000 - 9469952, 2000 - 9469952, -3000 - 9469952,
                            4000 - 9469952, 0));
    endtask

    task automatic test_turn_directed();
        send_item(make_item(OPC_TURN, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_TURN, 8388607, 0, 0, 0, 0, -8388608));
        // Heading swung the full way round and beyond.
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 8388607));
        send_item(make_item(OPC_TURN, 1000, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 500));
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 950));
    endtask

    task automatic test_config_extremes();
        // All registers at zero: a move with zero magnitude, a turn with no drive.
        set_controls(0, 0, 0, 0, 0, 0);
        send_item(make_item(OPC_MOVE, 100, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_TURN, 1, 0, 0, 0, 0, 0));
        // All registers at their top values: speed above 100 saturates.
        set_controls(127, 1023, 65535, 65535, 32767, 65535);
        send_item(make_item(OPC_MOVE, 5000, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 100000));
        send_item(make_item(OPC_TURN, 40000, 0, 0, 0, 0, 0));
        send_item(make_item(OPC_SAMPLE, 0, 0, 0, 0, 0, 10000));
        set_controls(SPEED_RST, DIST_MARG_RST, DIST_GAIN_RST, HEAD_GAIN_RST, TURN_MARG_RST,
                     TURN_GAIN_RST);
    endtask

    // Mostly well-formed runs with random content, some noise, under several settings.
    task automatic test_random_traffic();
        int phase, stop_at, pick;
        for (phase = 0; phase < 4; phase++)
        begin
            set_controls($urandom_range(0, 3) == 0 ? $urandom_range(101, 127)
                                                   : $urandom_range(0, 100),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 60),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 400),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 1024));
            send_idle_on = (phase != 1) && (phase != 3);
            recv_idle_on = (phase != 2) && (phase != 3);
            stop_at      = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    drive_move_run($urandom_range(1, 8));
                end
                else if (pick < 8)
                begin
                    drive_turn_run($urandom_range(1, 8));
                end
                else
                begin
                    send_noise();
                end
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // The result side holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        wait_idle();
        send_idle_on = 1'b0;
        hold_output  = 1'b1;
        drive_turn_run(6);
        drive_move_run(8);
        send_idle_on = 1'b1;
    endtask

    initial
    begin : main
        // Predictor starts from the reset state.
        ctl_cfg.speed_percent   = SPEED_RST;
        ctl_cfg.distance_margin = DIST_MARG_RST;
        ctl_cfg.distance_gain   = DIST_GAIN_RST;
        ctl_cfg.heading_gain    = HEAD_GAIN_RST;
        ctl_cfg.turn_margin     = TURN_MARG_RST;
        ctl_cfg.turn_gain       = TURN_GAIN_RST;
        drive_mode = MODE_IDLE;
        head_ref   = 0;
        turn_goal  = 0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            wheel_goal[i] = 0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_samples();
        test_move_directed();
        test_turn_directed();
        test_config_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("diff_drive_move_turn_p_control_core verification clean");
        end
        else
        begin
            $display("diff_drive_move_turn_p_control_core verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ddmt_pkg.sv
rtl/core/ddmt_cfg.sv
rtl/core/ddmt_ctrl.sv
rtl/core/ddmt_dpath.sv
rtl/core/diff_drive_move_turn_p_control_core.sv
test/tb.sv
